// ----- rtl/skiq_pkg.sv -----
package skiq_pkg;

	localparam int KeyWidth  = 32;
	localparam int ItemWidth = 32;
	localparam int FuncWidth = 3;
	localparam int CountOutWidth = 5;

	localparam logic [FuncWidth-1:0] FUNC_PREPEND    = 3'd0;
	localparam logic [FuncWidth-1:0] FUNC_APPEND     = 3'd1;
	localparam logic [FuncWidth-1:0] FUNC_SORTED     = 3'd2;
	localparam logic [FuncWidth-1:0] FUNC_REMOVE_HD  = 3'd3;
	localparam logic [FuncWidth-1:0] FUNC_REMOVE_KEY = 3'd4;

	localparam logic signed [KeyWidth-1:0] KEY_MIN = {1'b1, {(KeyWidth-1){1'b0}}};
	localparam logic signed [KeyWidth-1:0] KEY_MAX = {1'b0, {(KeyWidth-1){1'b1}}};

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_PREPEND,
		CMD_APPEND,
		CMD_SORTED,
		CMD_POP_HEAD,
		CMD_POP_KEY
	} cell_op_t;

	typedef struct packed {
		logic                       valid;
		logic signed [KeyWidth-1:0] key;
		logic [ItemWidth-1:0]       item;
	} entry_t;

	// broadcast to every cell in the row
	typedef struct packed {
		cell_op_t                   op;
		logic signed [KeyWidth-1:0] key;
		logic signed [KeyWidth-1:0] new_key;
		logic [ItemWidth-1:0]       item;
	} cell_cmd_t;

endpackage

// ----- rtl/skiq_cell.sv -----
module skiq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skiq_pkg::cell_cmd_t cmd,
	input  logic                prev_stay,
	input  skiq_pkg::entry_t    prev_entry,
	input  skiq_pkg::entry_t    next_entry,
	output skiq_pkg::entry_t    entry,
	output logic                stay,
	output logic                match
);

	logic                                 valid_q;
	logic signed [skiq_pkg::KeyWidth-1:0] key_q;
	logic [skiq_pkg::ItemWidth-1:0]       item_q;
	logic                                 ge;
	skiq_pkg::entry_t                     entry_d;

	assign entry = '{valid: valid_q, key: key_q, item: item_q};

	always_comb begin
		match = valid_q && (key_q == cmd.key);
		ge    = !valid_q || (key_q >= cmd.key);
		unique case (cmd.op)
			skiq_pkg::CMD_APPEND: stay = valid_q;
			skiq_pkg::CMD_SORTED: stay = valid_q && (key_q <= cmd.key);
			default:              stay = 1'b0;
		endcase
	end

	// insert: entries left of the slot stay, the slot takes the new entry, the rest shift right
	// remove: entries from the removed slot on shift left
	always_comb begin
		entry_d = entry;
		unique case (cmd.op)
			skiq_pkg::CMD_PREPEND, skiq_pkg::CMD_APPEND, skiq_pkg::CMD_SORTED: begin
				if (!stay) begin
					if (prev_stay) begin
						entry_d = '{valid: 1'b1, key: cmd.new_key, item: cmd.item};
					end else begin
						entry_d = prev_entry;
					end
				end
			end
			skiq_pkg::CMD_POP_HEAD: entry_d = next_entry;
			skiq_pkg::CMD_POP_KEY: begin
				if (ge) begin
					entry_d = next_entry;
				end
			end
			default: entry_d = entry;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= entry_d.key;
		item_q <= entry_d.item;
	end

endmodule

// ----- rtl/sorted_key_item_queue.sv -----
// A transaction accepted on s_* shows its result on m_* in the next cycle.
// Throughput: one transaction per cycle unless m_* stalls; every cell compares against
// the key and shifts toward its neighbor in the same cycle, so the row sets the rate.
// Output register: a new transaction is taken while the last result is being taken.
// Reset clears all valid bits, the entry count and m_tvalid; no clearing pass.
module sorted_key_item_queue #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // item_in[31:0], key_in[63:32]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // item_out[31:0], key_out[63:32], entry_count[68:64], zero
	output logic [1:0]  m_tuser   // hit[0], rejected[1]
);

	localparam int CW = $clog2(CAPACITY + 1);

	skiq_pkg::entry_t    entries [CAPACITY];
	logic [CAPACITY-1:0] stays;
	logic [CAPACITY-1:0] match_hits;
	logic [CAPACITY-1:0] valids;
	logic [CAPACITY-1:0] ordered;
	skiq_pkg::cell_cmd_t cmd;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	logic                                  m_tvalid_q;
	logic                                  hit_q;
	logic                                  rejected_q;
	logic [skiq_pkg::ItemWidth-1:0]        item_out_q;
	logic signed [skiq_pkg::KeyWidth-1:0]  key_out_q;
	logic [skiq_pkg::CountOutWidth-1:0]    count_out_q;

	logic                                  accept;
	logic [2:0]                            func;
	logic [skiq_pkg::ItemWidth-1:0]        item_in;
	logic signed [skiq_pkg::KeyWidth-1:0]  key_in;
	logic                                  full;
	logic                                  empty;
	logic                                  hit_any;
	logic signed [skiq_pkg::KeyWidth-1:0]  tail_key;
	logic signed [skiq_pkg::KeyWidth-1:0]  head_key;
	logic signed [skiq_pkg::KeyWidth-1:0]  match_key;
	logic [skiq_pkg::ItemWidth-1:0]        match_item;
	logic                                  hit_d;
	logic                                  rejected_d;
	logic [skiq_pkg::ItemWidth-1:0]        item_out_d;
	logic signed [skiq_pkg::KeyWidth-1:0]  key_out_d;

	assign accept  = s_tvalid && s_tready;
	assign func    = s_tuser;
	assign item_in = s_tdata[31:0];
	assign key_in  = s_tdata[63:32];
	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign head_key = entries[0].key;

	// the last valid cell and the first matching cell are each one-hot
	always_comb begin
		tail_key   = '0;
		match_key  = '0;
		match_item = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (entries[i].valid && (i == CAPACITY - 1 || !valids[(i + 1) % CAPACITY])) begin
				tail_key = tail_key | entries[i].key;
			end
			if (match_hits[i] && (i == 0 || !match_hits[(i + CAPACITY - 1) % CAPACITY])) begin
				match_key  = match_key | entries[i].key;
				match_item = match_item | entries[i].item;
			end
		end
		hit_any = |match_hits;
	end

	always_comb begin
		cmd.op      = skiq_pkg::CMD_HOLD;
		cmd.key     = key_in;
		cmd.new_key = key_in;
		cmd.item    = item_in;
		count_d     = count_q;
		hit_d       = 1'b0;
		rejected_d  = 1'b0;
		item_out_d  = '0;
		key_out_d   = '0;
		unique case (func)
			skiq_pkg::FUNC_PREPEND, skiq_pkg::FUNC_APPEND, skiq_pkg::FUNC_SORTED: begin
				if (full) begin
					rejected_d = 1'b1;
				end else begin
					count_d = count_q + CW'(1);
					if (func == skiq_pkg::FUNC_PREPEND) begin
						cmd.op = skiq_pkg::CMD_PREPEND;
						if (empty) begin
							cmd.new_key = '0;
						end else if (head_key == skiq_pkg::KEY_MIN) begin
							cmd.new_key = skiq_pkg::KEY_MIN;
						end else begin
							cmd.new_key = head_key - 32'sd1;
						end
					end else if (func == skiq_pkg::FUNC_APPEND) begin
						cmd.op = skiq_pkg::CMD_APPEND;
						if (empty) begin
							cmd.new_key = '0;
						end else if (tail_key == skiq_pkg::KEY_MAX) begin
							cmd.new_key = skiq_pkg::KEY_MAX;
						end else begin
							cmd.new_key = tail_key + 32'sd1;
						end
					end else begin
						cmd.op = skiq_pkg::CMD_SORTED;
					end
				end
			end
			skiq_pkg::FUNC_REMOVE_HD: begin
				if (!empty) begin
					cmd.op     = skiq_pkg::CMD_POP_HEAD;
					count_d    = count_q - CW'(1);
					hit_d      = 1'b1;
					item_out_d = entries[0].item;
					key_out_d  = entries[0].key;
				end
			end
			skiq_pkg::FUNC_REMOVE_KEY: begin
				if (hit_any) begin
					cmd.op     = skiq_pkg::CMD_POP_KEY;
					count_d    = count_q - CW'(1);
					hit_d      = 1'b1;
					item_out_d = match_item;
					key_out_d  = match_key;
				end
			end
			default: ;
		endcase
		if (!accept) begin
			cmd.op  = skiq_pkg::CMD_HOLD;
			count_d = count_q;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		skiq_pkg::entry_t prev_entry;
		skiq_pkg::entry_t next_entry;
		logic             prev_stay;

		if (g == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_stay  = 1'b1;
		end else begin : g_mid
			assign prev_entry = entries[g-1];
			assign prev_stay  = stays[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign next_entry = '0;
			assign ordered[g] = 1'b1;
		end else begin : g_body
			assign next_entry = entries[g+1];
			assign ordered[g] = !entries[g+1].valid ||
				(entries[g].valid && entries[g].key <= entries[g+1].key);
		end

		skiq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_stay  (prev_stay),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (entries[g]),
			.stay       (stays[g]),
			.match      (match_hits[g])
		);

		assign valids[g] = entries[g].valid;
	end

	assign s_tready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q       <= hit_d;
			rejected_q  <= rejected_d;
			item_out_q  <= item_out_d;
			key_out_q   <= key_out_d;
			count_out_q <= skiq_pkg::CountOutWidth'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, count_out_q, key_out_q, item_out_q};
	assign m_tuser  = {rejected_q, hit_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_valids: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == int'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&ordered)
		else $error("cell row not contiguous or not in key order");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit_d |=> count_q == $past(count_q) - CW'(1))
		else $error("remove hit did not shrink the list");

endmodule
